FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Assertions drop out when NO_ASSERTIONS
// is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(name, clk, rstn, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(name, clk, rstn, prop, msg)
`define ASSERT_NEVER(name, clk, rstn, cond, msg)

`endif

`endif

FILE: rtl/riffwav_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RIFF/WAVE header parser package
// Parse phases, status codes, tag constants and the result word layout.
// ----------------------------------------------------------------------------
package riffwav_pkg;

  typedef enum logic [3:0] {
    PH_RIFF  = 4'd0,
    PH_SIZE  = 4'd1,
    PH_WAVE  = 4'd2,
    PH_ID    = 4'd3,
    PH_LEN   = 4'd4,
    PH_SKIP  = 4'd5,
    PH_TAG   = 4'd6,
    PH_CHAN  = 4'd7,
    PH_RATE  = 4'd8,
    PH_BRATE = 4'd9,
    PH_ALIGN = 4'd10,
    PH_BITS  = 4'd11,
    PH_DONE  = 4'd12
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_RIFF  = 3'd1,
    ST_NOT_WAVE  = 3'd2,
    ST_NO_FMT    = 3'd3,
    ST_FMT_SHORT = 3'd4,
    ST_BAD_FMT   = 3'd5,
    ST_BAD_SIZE  = 3'd6,
    ST_NO_DATA   = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    KIND_PCM   = 2'd0,
    KIND_ALAW  = 2'd1,
    KIND_MULAW = 2'd2
  } kind_e;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] FMT_MIN  = 32'd16;

  localparam logic [15:0] FMT_TAG_PCM   = 16'd1;
  localparam logic [15:0] FMT_TAG_ALAW  = 16'd6;
  localparam logic [15:0] FMT_TAG_MULAW = 16'd7;

  // Declared from the highest bits down, so status lands in the lowest bits.
  typedef struct packed {
    logic [31:0] sample_count;
    logic [31:0] data_bytes;
    logic [2:0]  bytes_per_sample;
    logic [15:0] bits_per_sample;
    logic [15:0] block_align;
    logic [31:0] byte_rate;
    logic [31:0] sample_rate;
    logic [15:0] channels;
    logic [1:0]  format_kind;
    logic [15:0] format_tag;
    logic [2:0]  status;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/riff_wave_header_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RIFF/WAVE header parser
// Walks a WAVE file byte stream and reports the fmt fields and data length.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one word per file byte: tdata carries the byte,
// tuser[0] restarts the parser so that this byte is the first of a file, and
// tuser[1] marks the end of the stream (tdata is then ignored).
// The master channel gives one word per file: the status and, on success,
// the format fields, the data chunk length and the sample count. After that
// word the parser drops all bytes until a restart.
// Throughput is one byte per cycle while the slave side is not stalled. A
// byte is captured in an input register, updates the parse state from there
// and, if it ends the header, its result is loaded into the result register
// together with that update. When the receiver stalls, the result register
// holds its word and bytes that produce no result keep flowing; only a byte
// that would produce a second result waits in the input register, and the
// slave side stalls until the word is taken.
// Reset clears the parser to expect the RIFF tag and empties both registers.
// ----------------------------------------------------------------------------
module riff_wave_header_parser_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]   s_axis_tuser_i,   // [0] restart, [1] stream_end
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [2:0] status, [18:3] format_tag, [20:19] format_kind, [36:21] channels,
  // [68:37] sample_rate, [100:69] byte_rate, [116:101] block_align,
  // [132:117] bits_per_sample, [135:133] bytes_per_sample,
  // [167:136] data_bytes, [199:168] sample_count
  output logic [199:0] m_axis_tdata_o
);
  import riffwav_pkg::*;

  // Input register.
  logic        in_valid_q, in_valid_d;
  logic [7:0]  byte_q;
  logic        restart_q;
  logic        end_q;
  logic        s_accept;

  // Parse state.
  phase_e      phase_q, phase_d;
  logic [1:0]  bif_q, bif_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] accum_q, accum_d;
  logic [31:0] skip_q, skip_d;
  logic [15:0] fmt_tag_q, fmt_tag_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] brate_q, brate_d;
  logic [15:0] align_q, align_d;
  logic [15:0] bits_q, bits_d;

  // Result register.
  logic        out_valid_q, out_valid_d;
  result_t     result_q;
  result_t     res;
  logic        produce;
  logic        out_free;
  logic        advance;
  logic        result_load;

  // Working values.
  phase_e      e_phase;
  logic [1:0]  e_bif;
  logic [31:0] e_tag;
  logic [31:0] e_accum;
  logic [31:0] e_skip;
  logic [31:0] word_cur;
  logic [31:0] tag_cur;
  logic [31:0] skip_dec;
  logic [16:0] bits_sum;
  logic [13:0] bps_new;
  logic [16:0] held_sum;
  logic [13:0] bps_held;
  logic        last2;
  logic        last4;

  assign s_accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free    = !out_valid_q || m_axis_tready_i;
  assign advance     = in_valid_q && (!produce || out_free);
  assign result_load = advance && produce;

  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = result_q;

  always_comb begin
    in_valid_d  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = result_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);
  end

  always_comb begin
    // A restart clears the parser before this byte is looked at.
    e_phase = restart_q ? PH_RIFF : phase_q;
    e_bif   = restart_q ? 2'd0 : bif_q;
    e_tag   = restart_q ? 32'd0 : tag_q;
    e_accum = restart_q ? 32'd0 : accum_q;
    e_skip  = restart_q ? 32'd0 : skip_q;

    phase_d   = e_phase;
    bif_d     = e_bif;
    tag_d     = e_tag;
    accum_d   = e_accum;
    skip_d    = e_skip;
    fmt_tag_d = restart_q ? 16'd0 : fmt_tag_q;
    chan_d    = restart_q ? 16'd0 : chan_q;
    rate_d    = restart_q ? 32'd0 : rate_q;
    brate_d   = restart_q ? 32'd0 : brate_q;
    align_d   = restart_q ? 16'd0 : align_q;
    bits_d    = restart_q ? 16'd0 : bits_q;

    produce = 1'b0;
    res     = '0;

    word_cur = e_accum | ({24'd0, byte_q} << {e_bif, 3'b000});
    tag_cur  = {e_tag[23:0], byte_q};
    skip_dec = (e_skip != 32'd0) ? e_skip - 32'd1 : 32'd0;
    last2    = e_bif[0];
    last4    = (e_bif == 2'd3);

    bits_sum = {1'b0, word_cur[15:0]} + 17'd7;
    bps_new  = bits_sum[16:3];
    held_sum = {1'b0, bits_q} + 17'd7;
    bps_held = held_sum[16:3];

    if (e_phase < PH_DONE) begin
      if (end_q) begin
        produce = 1'b1;
        phase_d = PH_DONE;
        if (e_phase == PH_RIFF) begin
          res.status = ST_NOT_RIFF;
        end else if (e_phase == PH_SIZE || e_phase == PH_WAVE) begin
          res.status = ST_NOT_WAVE;
        end else if (bits_d != 16'd0) begin
          res.status = ST_NO_DATA;
        end else begin
          res.status = ST_NO_FMT;
        end
      end else begin
        unique case (e_phase)
          PH_RIFF, PH_WAVE, PH_ID: begin
            tag_d = tag_cur;
            bif_d = last4 ? 2'd0 : e_bif + 2'd1;
            if (last4) begin
              if (e_phase == PH_RIFF) begin
                if (tag_cur != TAG_RIFF) begin
                  produce    = 1'b1;
                  res.status = ST_NOT_RIFF;
                  phase_d    = PH_DONE;
                end else begin
                  phase_d = PH_SIZE;
                end
              end else if (e_phase == PH_WAVE) begin
                if (tag_cur != TAG_WAVE) begin
                  produce    = 1'b1;
                  res.status = ST_NOT_WAVE;
                  phase_d    = PH_DONE;
                end else begin
                  phase_d = PH_ID;
                end
              end else begin
                phase_d = PH_LEN;
              end
            end
          end
          PH_SIZE, PH_LEN, PH_RATE, PH_BRATE: begin
            accum_d = last4 ? 32'd0 : word_cur;
            bif_d   = last4 ? 2'd0 : e_bif + 2'd1;
            if (last4) begin
              case (e_phase)
                PH_SIZE:  phase_d = PH_WAVE;
                PH_RATE: begin
                  rate_d  = word_cur;
                  phase_d = PH_BRATE;
                end
                PH_BRATE: begin
                  brate_d = word_cur;
                  phase_d = PH_ALIGN;
                end
                default: begin
                  // Chunk length: the first fmt and a data chunk after it are acted on, others skipped.
                  if (bits_q == 16'd0 && e_tag == TAG_FMT) begin
                    if (word_cur < FMT_MIN) begin
                      produce    = 1'b1;
                      res.status = ST_FMT_SHORT;
                      phase_d    = PH_DONE;
                    end else begin
                      skip_d  = word_cur - FMT_MIN;
                      phase_d = PH_TAG;
                    end
                  end else if (bits_q != 16'd0 && e_tag == TAG_DATA) begin
                    produce              = 1'b1;
                    phase_d              = PH_DONE;
                    res.status           = ST_OK;
                    res.format_tag       = fmt_tag_q;
                    res.format_kind      = (fmt_tag_q == FMT_TAG_ALAW) ? KIND_ALAW :
                                           (fmt_tag_q == FMT_TAG_MULAW) ? KIND_MULAW :
                                           KIND_PCM;
                    res.channels         = chan_q;
                    res.sample_rate      = rate_q;
                    res.byte_rate        = brate_q;
                    res.block_align      = align_q;
                    res.bits_per_sample  = bits_q;
                    res.bytes_per_sample = bps_held[2:0];
                    res.data_bytes       = word_cur;
                    // Bytes per sample is 1, 2 or 4 here, so the divide is a shift.
                    res.sample_count     = word_cur >> {bps_held[2], bps_held[1]};
                  end else if (word_cur == 32'd0) begin
                    phase_d = PH_ID;
                  end else begin
                    skip_d  = word_cur;
                    phase_d = PH_SKIP;
                  end
                end
              endcase
            end
          end
          PH_SKIP: begin
            skip_d = skip_dec;
            if (skip_dec == 32'd0) begin
              phase_d = PH_ID;
            end
          end
          PH_TAG, PH_CHAN, PH_ALIGN, PH_BITS: begin
            accum_d = last2 ? 32'd0 : word_cur;
            bif_d   = last2 ? 2'd0 : e_bif + 2'd1;
            if (last2) begin
              case (e_phase)
                PH_TAG: begin
                  if (word_cur != {16'd0, FMT_TAG_PCM} &&
                      word_cur != {16'd0, FMT_TAG_ALAW} &&
                      word_cur != {16'd0, FMT_TAG_MULAW}) begin
                    produce    = 1'b1;
                    res.status = ST_BAD_FMT;
                    phase_d    = PH_DONE;
                  end else begin
                    fmt_tag_d = word_cur[15:0];
                    phase_d   = PH_CHAN;
                  end
                end
                PH_CHAN: begin
                  chan_d  = word_cur[15:0];
                  phase_d = PH_RATE;
                end
                PH_ALIGN: begin
                  align_d = word_cur[15:0];
                  phase_d = PH_BITS;
                end
                default: begin
                  if (bps_new != 14'd1 && bps_new != 14'd2 && bps_new != 14'd4) begin
                    produce    = 1'b1;
                    res.status = ST_BAD_SIZE;
                    phase_d    = PH_DONE;
                  end else begin
                    bits_d  = word_cur[15:0];
                    phase_d = (e_skip == 32'd0) ? PH_ID : PH_SKIP;
                  end
                end
              endcase
            end
          end
          default: begin
            phase_d = PH_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_RIFF;
      bif_q       <= 2'd0;
      tag_q       <= 32'd0;
      accum_q     <= 32'd0;
      skip_q      <= 32'd0;
      fmt_tag_q   <= 16'd0;
      chan_q      <= 16'd0;
      rate_q      <= 32'd0;
      brate_q     <= 32'd0;
      align_q     <= 16'd0;
      bits_q      <= 16'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        phase_q   <= phase_d;
        bif_q     <= bif_d;
        tag_q     <= tag_d;
        accum_q   <= accum_d;
        skip_q    <= skip_d;
        fmt_tag_q <= fmt_tag_d;
        chan_q    <= chan_d;
        rate_q    <= rate_d;
        brate_q   <= brate_d;
        align_q   <= align_d;
        bits_q    <= bits_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      byte_q    <= s_axis_tdata_i;
      restart_q <= s_axis_tuser_i[0];
      end_q     <= s_axis_tuser_i[1];
    end
    if (result_load) begin
      result_q <= res;
    end
  end

`include "assert_macros.svh"

  `ASSERT_PROP(a_done_after_result, clk_i, rst_ni,
               result_load |=> (phase_q == PH_DONE),
               "parser not finished after its result")
  `ASSERT_PROP(a_fmt_seen_phase, clk_i, rst_ni,
               (bits_q != 16'd0) |-> (phase_q == PH_ID || phase_q == PH_LEN ||
                                      phase_q == PH_SKIP || phase_q == PH_DONE),
               "fmt fields held while still reading fmt")
  `ASSERT_PROP(a_skip_aligned, clk_i, rst_ni,
               (phase_q == PH_SKIP) |-> (bif_q == 2'd0 && skip_q != 32'd0),
               "skip phase entered with stale field count")
  `ASSERT_PROP(a_ok_sample_size, clk_i, rst_ni,
               (out_valid_q && result_q.status == ST_OK) |->
                 (result_q.bytes_per_sample == 3'd1 || result_q.bytes_per_sample == 3'd2 ||
                  result_q.bytes_per_sample == 3'd4),
               "successful result with bad sample size")

endmodule

`default_nettype wire
